// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Both forms reduce to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Check that a condition never becomes true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== rtl/core/twm_pkg.sv =====
package twm_pkg;

  localparam int QUERY_MAX  = 16;
  localparam int LINE_BYTES = 65536;

  localparam int LEN_W   = $clog2(QUERY_MAX + 1);
  localparam int IDX_W   = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
  localparam int COUNT_W = $clog2(LINE_BYTES + 1);
  localparam int POS_W   = 16;
  localparam int QLEN_W  = 5;
  localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CASE_DELTA     = 8'h20;

  typedef enum logic [2:0] {
    REG_QUERY_LOW    = 3'd0,
    REG_QUERY_HIGH   = 3'd1,
    REG_QUERY_LENGTH = 3'd2,
    REG_MATCH_CASE   = 3'd3,
    REG_WHOLE_WORD   = 3'd4,
    REG_START_OFFSET = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] match_position;
    logic             line_end;
    logic             not_found;
  } out_item_t;

  typedef struct packed {
    logic [63:0]       query_low;
    logic [63:0]       query_high;
    logic [QLEN_W-1:0] query_length;
    logic              match_case;
    logic              whole_word;
    logic [POS_W-1:0]  start_offset;
  } cfg_t;

  // Classified byte handed from the front to the back.
  typedef struct packed {
    logic             is_word;
    logic             last;
    logic             ignored;
    logic             cand;
    logic [POS_W-1:0] cand_pos;
  } cls_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic exact);
    if (!exact && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      return b + CASE_DELTA;
    end
    return b;
  endfunction

  function automatic logic is_word_byte(input logic [7:0] b);
    return (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) ||
           (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
           (b >= CHAR_DIGIT_0 && b <= CHAR_DIGIT_9) ||
           (b == CHAR_UNDERSCORE);
  endfunction

endpackage

// ===== rtl/core/twm_front.sv =====
`include "assert_macros.svh"

module twm_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  twm_pkg::in_item_t in_data,
  input  twm_pkg::cfg_t    cfg,
  input  logic             q_full,
  output logic             push,
  output twm_pkg::cls_t    push_data
);

  logic [twm_pkg::COUNT_W-1:0]        count;
  logic [twm_pkg::COUNT_W-1:0]        count_inc;
  logic [twm_pkg::QUERY_MAX-2:0][7:0] byte_hist;
  logic [twm_pkg::QUERY_MAX-1:0][7:0] window;
  logic [twm_pkg::QUERY_MAX-1:0][7:0] query_fold;
  logic [twm_pkg::QUERY_MAX-1:0]      cmp_ok;
  logic [twm_pkg::QUERY_MAX:0]        word_hist;
  logic [twm_pkg::QUERY_MAX:0]        word_step;
  logic [twm_pkg::LEN_W-1:0]          len_eff;
  logic [twm_pkg::IDX_W-1:0]          len_top;
  logic [twm_pkg::COUNT_W-1:0]        start_pos;
  logic [127:0]                       query_flat;
  logic                               byte_word;
  logic                               ignored;
  logic                               cand;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  assign query_flat = {cfg.query_high, cfg.query_low};
  assign byte_word  = twm_pkg::is_word_byte(in_data.text_byte);
  assign ignored    = (count >= twm_pkg::COUNT_W'(twm_pkg::LINE_BYTES));
  assign count_inc  = count + 1'b1;
  assign word_step  = {word_hist[twm_pkg::QUERY_MAX-1:0], byte_word};
  // Entry 0 is the incoming byte, entry k the byte k items back.
  assign window     = {byte_hist, in_data.text_byte};

  // Clamp the query length to the window size.
  always_comb begin
    if (cfg.query_length > twm_pkg::QLEN_W'(twm_pkg::QUERY_MAX)) begin
      len_eff = twm_pkg::LEN_W'(twm_pkg::QUERY_MAX);
    end else begin
      len_eff = twm_pkg::LEN_W'(cfg.query_length);
    end
  end

  assign len_top = twm_pkg::IDX_W'(len_eff - 1'b1);

  // Compare the newest len_eff bytes against the query as it stands now:
  // window byte k meets query byte len_eff-1-k; positions past the length pass.
  always_comb begin
    for (int j = 0; j < twm_pkg::QUERY_MAX; j++) begin
      query_fold[j] = twm_pkg::fold_byte(query_flat[8*j +: 8], cfg.match_case);
    end
    for (int k = 0; k < twm_pkg::QUERY_MAX; k++) begin
      cmp_ok[k] = (twm_pkg::LEN_W'(k) >= len_eff) ||
                  (twm_pkg::fold_byte(window[k], cfg.match_case) ==
                   query_fold[len_top - twm_pkg::IDX_W'(k)]);
    end
  end

  assign start_pos = count_inc - twm_pkg::COUNT_W'(len_eff);

  always_comb begin
    cand = 1'b0;
    if (!ignored && len_eff != '0 && count_inc >= twm_pkg::COUNT_W'(len_eff)) begin
      cand = (&cmp_ok) &&
             (twm_pkg::CMP_W'(start_pos) >= twm_pkg::CMP_W'(cfg.start_offset)) &&
             !(cfg.whole_word && start_pos != '0 && word_step[len_eff]);
    end
  end

  always_comb begin
    push_data.is_word  = byte_word;
    push_data.last     = in_data.last_byte;
    push_data.ignored  = ignored;
    push_data.cand     = cand;
    push_data.cand_pos = twm_pkg::POS_W'(start_pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      byte_hist <= '0;
      word_hist <= '0;
    end else if (push) begin
      if (in_data.last_byte) begin
        count     <= '0;
        byte_hist <= '0;
        word_hist <= '0;
      end else if (!ignored) begin
        count     <= count_inc;
        byte_hist <= window[twm_pkg::QUERY_MAX-2:0];
        word_hist <= word_step;
      end
    end
  end

  `ASSERT_PROP(front_line_clear, clk, rst, push && in_data.last_byte |=> count == '0)

endmodule

// ===== rtl/core/twm_queue.sv =====
`include "assert_macros.svh"

module twm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  twm_pkg::cls_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output twm_pkg::cls_t pop_data
);

  twm_pkg::cls_t               entries [twm_pkg::QDEPTH];
  logic [twm_pkg::QPTR_W-1:0]  wr_ptr;
  logic [twm_pkg::QPTR_W-1:0]  rd_ptr;
  logic [twm_pkg::QCNT_W-1:0]  fill;

  assign full      = (fill == twm_pkg::QCNT_W'(twm_pkg::QDEPTH));
  assign pop_valid = (fill != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == twm_pkg::QPTR_W'(twm_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == twm_pkg::QPTR_W'(twm_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(queue_overflow, clk, rst, push && full && !pop)
  `ASSERT_NEVER(queue_underflow, clk, rst, pop && !pop_valid)

endmodule

// ===== rtl/core/twm_back.sv =====
`include "assert_macros.svh"

module twm_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              whole_word,
  input  logic              q_valid,
  input  twm_pkg::cls_t     entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output twm_pkg::out_item_t out_data
);

  logic                      pending_match;
  logic                      pending_match_next;
  logic [twm_pkg::POS_W-1:0] pending_position;
  logic [twm_pkg::POS_W-1:0] pending_position_next;
  logic                      already_found;
  logic                      already_found_next;
  twm_pkg::out_item_t        result;

  assign pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    pending_match_next    = pending_match;
    pending_position_next = pending_position;
    already_found_next    = already_found;
    result                = '0;
    if (!entry.ignored) begin
      // Confirm the waiting candidate unless whole-word mode is on and a word byte follows it.
      if (pending_match) begin
        if (!whole_word || !entry.is_word) begin
          result.hit            = 1'b1;
          result.match_position = pending_position;
          already_found_next    = 1'b1;
        end
        pending_match_next = 1'b0;
      end
      if (!already_found_next && entry.cand) begin
        if (entry.last) begin
          result.hit            = 1'b1;
          result.match_position = entry.cand_pos;
          already_found_next    = 1'b1;
        end else begin
          pending_match_next    = 1'b1;
          pending_position_next = entry.cand_pos;
        end
      end
    end else if (pending_match) begin
      // Line limit acts as the line end.
      result.hit            = 1'b1;
      result.match_position = pending_position;
      already_found_next    = 1'b1;
      pending_match_next    = 1'b0;
    end
    result.line_end  = entry.last;
    result.not_found = entry.last && !already_found_next;
    if (entry.last) begin
      pending_match_next    = 1'b0;
      pending_position_next = '0;
      already_found_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_match    <= 1'b0;
      pending_position <= '0;
      already_found    <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        pending_match    <= pending_match_next;
        pending_position <= pending_position_next;
        already_found    <= already_found_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= result;
    end
  end

  `ASSERT_NEVER(back_found_no_pending, clk, rst, already_found && pending_match)
  `ASSERT_NEVER(back_hit_not_found, clk, rst, out_valid && out_data.hit && out_data.not_found)
  `ASSERT_PROP(back_line_reset, clk, rst, pop && entry.last |=> !pending_match && !already_found)

endmodule

// ===== rtl/core/text_find_whole_word_matcher.sv =====
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | in_data   (text_byte, last_byte)
// out     | output    | out_valid / out_ready | out_data  (hit, match_position,
//         |           |                       |            line_end, not_found)
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte per cycle sustained while out_ready keeps up; out_valid rises once the byte
// is through the queue (front pushes it into the queue, back registers the result).
// The front's window compare and the back's pending-match update set the rate.
// Synchronous active-high rst clears line state, the queue, out_valid and
// all configuration registers. No clearing pass is needed.
// Output stalls fill the two-entry queue; in_ready drops only when it is full.

module text_find_whole_word_matcher (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  twm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output twm_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  // Configuration registers: the user must write them only while the block is idle; the block does not enforce it.
  twm_pkg::cfg_t cfg;

  // Front to queue.
  logic          push;
  twm_pkg::cls_t push_data;
  logic          q_full;

  // Queue to back.
  logic          pop;
  logic          q_valid;
  twm_pkg::cls_t q_data;

  // Every configuration transaction is taken at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (twm_pkg::cfg_reg_t'(cfg_index))
        twm_pkg::REG_QUERY_LOW:    cfg.query_low    <= cfg_data;
        twm_pkg::REG_QUERY_HIGH:   cfg.query_high   <= cfg_data;
        twm_pkg::REG_QUERY_LENGTH: cfg.query_length <= cfg_data[twm_pkg::QLEN_W-1:0];
        twm_pkg::REG_MATCH_CASE:   cfg.match_case   <= cfg_data[0];
        twm_pkg::REG_WHOLE_WORD:   cfg.whole_word   <= cfg_data[0];
        twm_pkg::REG_START_OFFSET: cfg.start_offset <= cfg_data[twm_pkg::POS_W-1:0];
        default: begin
          // Unmapped index: drop the write.
        end
      endcase
    end
  end

  // Front: take each byte, advance the window and flag match candidates.
  twm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // Short queue that lets the front keep accepting while the output stalls.
  twm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  // Back: confirm candidates on the following byte, hold the first hit of the line.
  twm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .whole_word (cfg.whole_word),
    .q_valid    (q_valid),
    .entry      (q_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== tb/tb_text_find_whole_word_matcher.sv =====
// Tracks the search state of one line and predicts the result of every byte.
class match_tracker;
  logic [63:0] query_low;
  logic [63:0] query_high;
  logic [4:0]  query_len;
  logic        exact_case;
  logic        whole_word;
  logic [15:0] start_pos;

  logic [7:0]  history [twm_pkg::QUERY_MAX+1];
  int unsigned byte_count;
  bit          cand_pending;
  logic [15:0] cand_pos;
  bit          line_found;

  twm_pkg::out_item_t expected_reports[$];
  int unsigned        mismatches;
  int unsigned        bytes_taken;

  function new();
    query_low   = '0;
    query_high  = '0;
    query_len   = '0;
    exact_case  = 1'b0;
    whole_word  = 1'b0;
    start_pos   = '0;
    mismatches  = 0;
    bytes_taken = 0;
    clear_line();
  endfunction

  function void clear_line();
    foreach (history[i]) history[i] = 8'h00;
    byte_count   = 0;
    cand_pending = 1'b0;
    cand_pos     = '0;
    line_found   = 1'b0;
  endfunction

  function logic [7:0] fold(logic [7:0] b);
    if (!exact_case && b >= "A" && b <= "Z") return b + 8'h20;
    return b;
  endfunction

  function bit is_word(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
           (b >= "0" && b <= "9") || (b == "_");
  endfunction

  function logic [7:0] query_byte(int i);
    if (i < 8) return query_low[i*8 +: 8];
    return query_high[(i-8)*8 +: 8];
  endfunction

  function void write_reg(twm_pkg::cfg_reg_t idx, logic [63:0] v);
    case (idx)
      twm_pkg::REG_QUERY_LOW:    query_low  = v;
      twm_pkg::REG_QUERY_HIGH:   query_high = v;
      twm_pkg::REG_QUERY_LENGTH: query_len  = v[4:0];
      twm_pkg::REG_MATCH_CASE:   exact_case = v[0];
      twm_pkg::REG_WHOLE_WORD:   whole_word = v[0];
      twm_pkg::REG_START_OFFSET: start_pos  = v[15:0];
      default: ;
    endcase
  endfunction

  function void take_byte(twm_pkg::in_item_t item);
    twm_pkg::out_item_t rpt;
    int unsigned len;
    int unsigned s;
    bit ok;
    rpt = '0;
    bytes_taken++;
    len = (query_len > twm_pkg::QUERY_MAX) ? twm_pkg::QUERY_MAX : query_len;
    if (byte_count < twm_pkg::LINE_BYTES) begin
      // A waiting candidate is judged by the byte that follows it.
      if (cand_pending) begin
        if (!whole_word || !is_word(item.text_byte)) begin
          rpt.hit = 1'b1;
          rpt.match_position = cand_pos;
          line_found = 1'b1;
        end
        cand_pending = 1'b0;
      end
      for (int i = twm_pkg::QUERY_MAX; i > 0; i--) history[i] = history[i-1];
      history[0] = item.text_byte;
      byte_count++;
      if (!line_found && len > 0 && byte_count >= len) begin
        s  = byte_count - len;
        ok = (s >= start_pos);
        for (int i = 0; i < len; i++) begin
          if (fold(query_byte(i)) != fold(history[len-1-i])) ok = 1'b0;
        end
        if (ok && whole_word && s > 0 && is_word(history[len])) ok = 1'b0;
        if (ok) begin
          if (item.last_byte) begin
            rpt.hit = 1'b1;
            rpt.match_position = s[15:0];
            line_found = 1'b1;
          end else begin
            cand_pending = 1'b1;
            cand_pos = s[15:0];
          end
        end
      end
    end else if (cand_pending) begin
      // Past the line limit: the line is over, so the candidate stands.
      rpt.hit = 1'b1;
      rpt.match_position = cand_pos;
      line_found = 1'b1;
      cand_pending = 1'b0;
    end
    if (item.last_byte) begin
      rpt.line_end  = 1'b1;
      rpt.not_found = !line_found;
      clear_line();
    end
    expected_reports.push_back(rpt);
  endfunction

  function void check_report(twm_pkg::out_item_t got);
    twm_pkg::out_item_t want;
    if (expected_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: hit=%0b pos=%0d end=%0b none=%0b",
                 got.hit, got.match_position, got.line_end, got.not_found);
      return;
    end
    want = expected_reports.pop_front();
    if (got.hit !== want.hit || got.match_position !== want.match_position ||
        got.line_end !== want.line_end || got.not_found !== want.not_found) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"result mismatch: expected hit=%0b pos=%0d end=%0b none=%0b,",
                  " got hit=%0b pos=%0d end=%0b none=%0b"},
                 want.hit, want.match_position, want.line_end, want.not_found,
                 got.hit, got.match_position, got.line_end, got.not_found);
    end
  endfunction
endclass

module tb_text_find_whole_word_matcher;

  localparam int IDLE_MAX     = 13;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASES       = 12;
  localparam int PHASE_BYTES  = 85;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  twm_pkg::in_item_t   in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  twm_pkg::out_item_t  out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = twm_pkg::REG_QUERY_LOW;
  logic [63:0]         cfg_data  = '0;

  match_tracker tracker = new();
  int unsigned  cycle_count = 0;

  text_find_whole_word_matcher u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: hold off for a random stall, possibly none, then take one transaction.
  // Signals read right after the edge hold the values the block saw at that edge.
  initial begin : result_sink
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, IDLE_MAX);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tracker.check_report(out_data);
    end
  end

  // Hold a byte on the input channel until the block takes it, after a random gap.
  task automatic send_byte(logic [7:0] b, bit last);
    int unsigned       gap;
    twm_pkg::in_item_t item;
    gap = $urandom_range(0, IDLE_MAX);
    item.text_byte = b;
    item.last_byte = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    tracker.take_byte(item);
  endtask

  // Send a whole line; the final character carries the line end.
  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // Drop valid and wait out every expected result plus the pipeline depth.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(twm_pkg::cfg_reg_t idx, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, v);
  endtask

  // Reprogram every register once the block has gone quiet.
  task automatic load_search(logic [127:0] query, logic [4:0] len, bit exact, bit whole,
                             logic [15:0] start);
    wait_idle();
    write_reg(twm_pkg::REG_QUERY_LOW, query[63:0]);
    write_reg(twm_pkg::REG_QUERY_HIGH, query[127:64]);
    write_reg(twm_pkg::REG_QUERY_LENGTH, 64'(len));
    write_reg(twm_pkg::REG_MATCH_CASE, 64'(exact));
    write_reg(twm_pkg::REG_WHOLE_WORD, 64'(whole));
    write_reg(twm_pkg::REG_START_OFFSET, 64'(start));
    cfg_valid <= 1'b0;
  endtask

  // Byte 0 of the query lands in the low eight bits.
  function automatic logic [127:0] pack_query(string s);
    logic [127:0] v;
    v = '0;
    for (int i = 0; i < s.len() && i < 16; i++) v[i*8 +: 8] = s[i];
    return v;
  endfunction

  function automatic logic [7:0] random_word_byte();
    case ($urandom_range(0, 3))
      0:       return 8'("a" + $urandom_range(0, 25));
      1:       return 8'("A" + $urandom_range(0, 25));
      2:       return 8'("0" + $urandom_range(0, 9));
      default: return "_";
    endcase
  endfunction

  // Bytes that always count as a word boundary.
  function automatic logic [7:0] random_gap_byte();
    case ($urandom_range(0, 4))
      0:       return " ";
      1:       return ".";
      2:       return ",";
      3:       return 8'h80 | 8'($urandom_range(0, 127));
      default: return 8'($urandom_range(0, 8'h2F));
    endcase
  endfunction

  function automatic logic [127:0] random_query();
    logic [127:0] q;
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < 16; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2:  q[i*8 +: 8] = random_gap_byte();
        3, 4:     q[i*8 +: 8] = 8'($urandom_range(0, 255));
        default:  q[i*8 +: 8] = random_word_byte();
      endcase
    end
    return q;
  endfunction

  // Build a line from copies of the query (case-flipped, now and then damaged),
  // boundary bytes, word bytes and noise, then send it.
  task automatic send_random_line();
    logic [7:0]  text[$];
    logic [7:0]  c;
    int unsigned target;
    int unsigned len;
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 24);
    len = (tracker.query_len > twm_pkg::QUERY_MAX) ? twm_pkg::QUERY_MAX : tracker.query_len;
    while (text.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          for (int i = 0; i < len; i++) begin
            c = tracker.query_byte(i);
            if (!tracker.exact_case && $urandom_range(0, 1) &&
                ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")))
              c = c ^ 8'h20;
            if ($urandom_range(0, 15) == 0) c = 8'($urandom_range(0, 255));
            text.push_back(c);
          end
        end
        4, 5:    text.push_back(random_gap_byte());
        6, 7:    text.push_back(random_word_byte());
        default: text.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
  endtask

  initial begin : stimulus
    int unsigned  sent;
    logic [4:0]   len;
    logic [15:0]  start;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Registers still at reset: empty query, nothing can match.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Case-folded whole word: line edges as boundaries, a word byte before,
    // an underscore after, then a match confirmed by the following byte.
    load_search(pack_query("Ab"), 5'd2, 1'b0, 1'b1, 16'd0);
    send_text("aB");
    send_text("xab ab_ AB.");

    // Exact case, substring mode: only the exact-case copy matches.
    load_search(pack_query("Ab"), 5'd2, 1'b1, 1'b0, 16'd0);
    send_text("ab Ab");

    // Zero length never matches, even on identical text.
    load_search(pack_query("Ab"), 5'd0, 1'b1, 1'b0, 16'd0);
    send_text("Ab");

    // Length above the maximum falls back to the full 16-byte query.
    load_search(pack_query("Query_Len_16_max"), 5'd31, 1'b1, 1'b1, 16'd0);
    send_text("Query_Len_16_max");

    // Random phases: mostly short queries and small offsets, with the extremes mixed in.
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 9))
        0:       len = 5'd0;
        1:       len = 5'd16;
        2:       len = 5'($urandom_range(17, 31));
        default: len = 5'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 7))
        0, 1, 2, 3: start = 16'd0;
        4, 5:       start = 16'($urandom_range(1, 12));
        6:          start = 16'hFFFF;
        default:    start = 16'($urandom_range(0, 65535));
      endcase
      load_search(random_query(), len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  start);
      sent = tracker.bytes_taken;
      while (tracker.bytes_taken < sent + PHASE_BYTES) send_random_line();
    end

    wait_idle();
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
